// ----- design/radio_frame_builder_fletcher_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radio frame builder
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIO_FRAME_BUILDER_FLETCHER_CORE_ASSERT_SVH
`define RADIO_FRAME_BUILDER_FLETCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// cond must hold at every edge
`define RFBF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cond must hold in the cycle after trig
`define RFBF_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`else

`define RFBF_ASSERT(label, cond, msg)
`define RFBF_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

// ----- design/rfbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rfbf_pkg
// Shared types and constants of the radio frame builder.
// ----------------------------------------------------------------------------
package rfbf_pkg;

  localparam int RFBF_MAX_PAYLOAD = 255;
  localparam int RFBF_QUEUE_DEPTH = 4;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes
  localparam logic [2:0] REG_SYNC_FIRST    = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND   = 3'd1;
  localparam logic [2:0] REG_COMMAND_CLASS = 3'd2;
  localparam logic [2:0] REG_TRANSMIT_CODE = 3'd3;
  localparam logic [2:0] REG_RADIO_ENABLED = 3'd4;

  localparam logic [7:0] RST_SYNC_FIRST    = 8'd72;
  localparam logic [7:0] RST_SYNC_SECOND   = 8'd101;
  localparam logic [7:0] RST_COMMAND_CLASS = 8'd16;
  localparam logic [7:0] RST_TRANSMIT_CODE = 8'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [7:0] PARAM_BYTE = 8'h00;

  typedef struct packed {
    logic       op;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       refused;
  } out_word_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] command_class;
    logic [7:0] transmit_code;
    logic       radio_enabled;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_REFUSE
  } cmd_kind_t;

  // value: clamped length for a start, payload byte for data
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;
    logic       last;
  } cmd_t;

  // back end byte position within a frame
  typedef enum logic [3:0] {
    STEP_SYNC0,
    STEP_SYNC1,
    STEP_CMD,
    STEP_CODE,
    STEP_PARAM,
    STEP_LEN,
    STEP_HCHK_A,
    STEP_HCHK_B,
    STEP_FIN_A,
    STEP_FIN_B
  } step_t;

endpackage

// ----- design/rfbf_regs.sv -----
// ----------------------------------------------------------------------------
// rfbf_regs
// APB configuration registers of the frame builder.
// ----------------------------------------------------------------------------
module rfbf_regs
  import rfbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first    <= RST_SYNC_FIRST;
      cfg_r.sync_second   <= RST_SYNC_SECOND;
      cfg_r.command_class <= RST_COMMAND_CLASS;
      cfg_r.transmit_code <= RST_TRANSMIT_CODE;
      cfg_r.radio_enabled <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_SYNC_FIRST:    cfg_r.sync_first    <= pwdata[7:0];
        REG_SYNC_SECOND:   cfg_r.sync_second   <= pwdata[7:0];
        REG_COMMAND_CLASS: cfg_r.command_class <= pwdata[7:0];
        REG_TRANSMIT_CODE: cfg_r.transmit_code <= pwdata[7:0];
        REG_RADIO_ENABLED: cfg_r.radio_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYNC_FIRST:    prdata = {24'd0, cfg_r.sync_first};
      REG_SYNC_SECOND:   prdata = {24'd0, cfg_r.sync_second};
      REG_COMMAND_CLASS: prdata = {24'd0, cfg_r.command_class};
      REG_TRANSMIT_CODE: prdata = {24'd0, cfg_r.transmit_code};
      REG_RADIO_ENABLED: prdata = {31'd0, cfg_r.radio_enabled};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- design/rfbf_front.sv -----
// ----------------------------------------------------------------------------
// rfbf_front
// Accepts input words, tracks frame state and queues commands for the back end.
// ----------------------------------------------------------------------------
module rfbf_front
  import rfbf_pkg::*;
#(
  parameter int MAX_PAYLOAD = RFBF_MAX_PAYLOAD
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  input  logic     radio_enabled,
  output logic     push,
  output cmd_t     push_cmd,
  input  logic     q_full
);

  logic       open_r, open_nxt;
  logic [7:0] left_r, left_nxt;
  logic       accept;
  logic [7:0] len_clamped;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign len_clamped = (in_word.payload_length > 8'(MAX_PAYLOAD)) ?
                       8'(MAX_PAYLOAD) : in_word.payload_length;

  always_comb begin
    open_nxt = open_r;
    left_nxt = left_r;
    push     = 1'b0;
    push_cmd = '{kind: CMD_DATA, value: in_word.data_byte, last: 1'b0};
    if (accept) begin
      if (in_word.op == OP_START) begin
        push = 1'b1;
        if (!radio_enabled) begin
          push_cmd = '{kind: CMD_REFUSE, value: 8'd0, last: 1'b1};
          open_nxt = 1'b0;
          left_nxt = 8'd0;
        end else begin
          push_cmd = '{kind: CMD_START, value: len_clamped, last: 1'b0};
          open_nxt = (len_clamped != 8'd0);
          left_nxt = len_clamped;
        end
      end else if (open_r) begin
        push          = 1'b1;
        push_cmd.last = (left_r == 8'd1);
        left_nxt      = left_r - 8'd1;
        open_nxt      = (left_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= 8'd0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// ----- design/rfbf_fifo.sv -----
// ----------------------------------------------------------------------------
// rfbf_fifo
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rfbf_fifo
  import rfbf_pkg::*;
#(
  parameter int DEPTH = RFBF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = mem[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ----- design/rfbf_back.sv -----
// ----------------------------------------------------------------------------
// rfbf_back
// Expands queued commands into frame bytes and keeps the Fletcher sums.
// ----------------------------------------------------------------------------
`include "radio_frame_builder_fletcher_core_assert.svh"

module rfbf_back
  import rfbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cmd_t      q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  step_t      step_r, step_nxt;
  logic [7:0] sum_lo_r, sum_lo_nxt;
  logic [7:0] sum_hi_r, sum_hi_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r;

  logic       advance;
  logic       acc, clr, done;
  out_word_t  word;

  assign advance   = q_valid & (~out_valid_r | out_ready);
  assign pop       = advance & done;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // byte for the current (head, step) pair
  always_comb begin
    word     = '{out_byte: 8'd0, frame_end: 1'b0, refused: 1'b0};
    acc      = 1'b0;
    clr      = 1'b0;
    done     = 1'b0;
    step_nxt = step_t'(step_r + 4'd1);
    hold_nxt = hold_r;
    if (q_head.kind == CMD_REFUSE) begin
      word.refused = 1'b1;
      done         = 1'b1;
    end else begin
      case (step_r)
        STEP_SYNC0: begin
          if (q_head.kind == CMD_DATA) begin
            word.out_byte = q_head.value;
            acc           = 1'b1;
            if (q_head.last) begin
              step_nxt = STEP_FIN_A;
            end else begin
              done = 1'b1;
            end
          end else begin
            word.out_byte = cfg.sync_first;
            clr           = 1'b1;
          end
        end
        STEP_SYNC1: begin
          word.out_byte = cfg.sync_second;
        end
        STEP_CMD: begin
          word.out_byte = cfg.command_class;
          acc           = 1'b1;
        end
        STEP_CODE: begin
          word.out_byte = cfg.transmit_code;
          acc           = 1'b1;
        end
        STEP_PARAM: begin
          word.out_byte = PARAM_BYTE;
          acc           = 1'b1;
        end
        STEP_LEN: begin
          word.out_byte = q_head.value;
          acc           = 1'b1;
        end
        STEP_HCHK_A: begin
          // second header byte is the sum of sums from before this one
          word.out_byte = sum_lo_r;
          acc           = 1'b1;
          hold_nxt      = sum_hi_r;
        end
        STEP_HCHK_B: begin
          word.out_byte = hold_r;
          acc           = 1'b1;
          if (q_head.value == 8'd0) begin
            step_nxt = STEP_FIN_A;
          end else begin
            done = 1'b1;
          end
        end
        STEP_FIN_A: begin
          word.out_byte = sum_lo_r;
        end
        STEP_FIN_B: begin
          word.out_byte  = sum_hi_r;
          word.frame_end = 1'b1;
          done           = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    if (done) begin
      step_nxt = STEP_SYNC0;
    end
  end

  always_comb begin
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    if (clr) begin
      sum_lo_nxt = 8'd0;
      sum_hi_nxt = 8'd0;
    end else if (acc) begin
      sum_lo_nxt = sum_lo_r + word.out_byte;
      sum_hi_nxt = sum_hi_r + sum_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_SYNC0;
      sum_lo_r    <= 8'd0;
      sum_hi_r    <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        step_r   <= step_nxt;
        sum_lo_r <= sum_lo_nxt;
        sum_hi_r <= sum_hi_nxt;
      end
      out_valid_r <= advance | (out_valid_r & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= word;
      hold_r     <= hold_nxt;
    end
  end

  `RFBF_ASSERT(a_step_range, step_r <= STEP_FIN_B, "step counter out of range")
  `RFBF_ASSERT(a_refuse_clean, !(out_valid_r && out_word_r.refused && (out_word_r.frame_end || out_word_r.out_byte != 8'd0)), "refused word carries frame data")
  `RFBF_ASSERT_NEXT(a_pop_rewinds, pop, step_r == STEP_SYNC0, "step not rewound after pop")

endmodule

// ----- design/radio_frame_builder_fletcher_core.sv -----
// ----------------------------------------------------------------------------
// radio_frame_builder_fletcher_core
// Radio transmit frame builder with 8-bit Fletcher-style header and frame checksums (sums modulo 256).
// ----------------------------------------------------------------------------
// A start word yields 8 output words (sync, sync, command, code, param, length,
// header checksum pair) plus the final checksum pair when the length is zero;
// a payload word yields one word, plus the final pair on the last payload byte;
// a refused start yields one word. While out_ready is high the back end emits
// one output word per cycle from the head of a command queue of QUEUE_DEPTH
// entries, so payload words flow at one per cycle, and the front end keeps
// accepting input words while the queue has room, i.e. while a header or
// checksum burst drains. No clearing pass: the block is ready right after reset.
module radio_frame_builder_fletcher_core
  import rfbf_pkg::*;
#(
  parameter int MAX_PAYLOAD = RFBF_MAX_PAYLOAD,
  parameter int QUEUE_DEPTH = RFBF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic push, q_full, pop, q_valid;
  cmd_t push_cmd, q_head;

  rfbf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfbf_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .radio_enabled (cfg.radio_enabled),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  rfbf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  rfbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
